/* src/tcrd_pkg.sv */
// ----------------------------------------------------------------------------
// tcrd_pkg
// shared types, constants and a bcd helper for the time-code record deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcrd_pkg;

  // width of the running record counter
  localparam int COUNT_WIDTH = 16;

  localparam logic [7:0] MARK_TIME = 8'hF7;
  localparam logic [7:0] MARK_USER = 8'hFF;

  // flag bit positions inside the gathered anomaly flags
  localparam int FLAG_RESYNC  = 0;
  localparam int FLAG_EARLY   = 1;
  localparam int FLAG_SKIPPED = 2;
  localparam int FLAG_COUNT   = 3;

  typedef enum logic [3:0] {
    PH_HUNT_TC = 4'd0,
    PH_FRAME   = 4'd1,
    PH_SEC     = 4'd2,
    PH_MIN     = 4'd3,
    PH_HOUR    = 4'd4,
    PH_HUNT_UB = 4'd5,
    PH_USER0   = 4'd6,
    PH_USER1   = 4'd7,
    PH_USER2   = 4'd8,
    PH_USER3   = 4'd9
  } phase_t;

  // packed bcd byte to 10*high + low, no digit check, range 0..165
  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

`default_nettype wire

/* src/timecode_record_deframer.sv */
// ----------------------------------------------------------------------------
// timecode_record_deframer
// deframes time-code records (marker, bcd time, marker, user bytes) from a
// byte stream and emits one record request per completed record
// ----------------------------------------------------------------------------
//
// channel   dir  width           contents
// s_*       in   tdata 8         one raw stream byte per request
// m_*       out  tdata 80, tuser 3  one decoded record per request
//
// - one byte is taken per cycle unless the fourth user byte waits; each byte
//   steps phase and updates bcd-decoded fields and flags before the registers
// - a record leaves through a single output register in the cycle after its
//   fourth user byte is taken
// - bytes that finish no record are taken even while a record waits at the
//   output; the fourth user byte waits only when the output register is full
//   and not being drained
// - rst is synchronous, active high: phase goes to hunting the time-code
//   marker, held time, user bytes, flags and the record counter clear
//
`timescale 1ns / 1ps
`default_nettype none

module timecode_record_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side: raw stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  // master side: decoded records
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // [15:0] record_number, [23:16] hours,
                                      // [31:24] minutes, [39:32] seconds,
                                      // [47:40] frames, [79:48] user_word
  output logic [2:0]       m_tuser    // [0] resync_seen,
                                      // [1] early_user_marker, [2] time_skipped
);

  // deframer state
  tcrd_pkg::phase_t                      phase;
  tcrd_pkg::phase_t                      phase_next;
  logic [7:0]                            held_frames;
  logic [7:0]                            held_seconds;
  logic [7:0]                            held_minutes;
  logic [7:0]                            held_hours;
  logic [23:0]                           partial_user_bytes;
  logic [tcrd_pkg::COUNT_WIDTH-1:0]      record_counter;
  logic [tcrd_pkg::FLAG_COUNT-1:0]       anomaly_flags;

  logic [7:0]                            held_frames_next;
  logic [7:0]                            held_seconds_next;
  logic [7:0]                            held_minutes_next;
  logic [7:0]                            held_hours_next;
  logic [23:0]                           partial_user_bytes_next;
  logic [tcrd_pkg::FLAG_COUNT-1:0]       anomaly_flags_next;

  logic       in_accept;
  logic       emit;          // accepted byte completes a record
  logic [7:0] decoded;

  // output register is free this cycle, or only plain bytes are coming
  assign s_tready  = (phase != tcrd_pkg::PH_USER3) || !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign emit      = in_accept && (phase == tcrd_pkg::PH_USER3);
  assign decoded   = tcrd_pkg::bcd_decode(s_tdata);

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      tcrd_pkg::PH_FRAME: phase_next = tcrd_pkg::PH_SEC;
      tcrd_pkg::PH_SEC:   phase_next = tcrd_pkg::PH_MIN;
      tcrd_pkg::PH_MIN:   phase_next = tcrd_pkg::PH_HOUR;
      tcrd_pkg::PH_HOUR: begin
        // hour byte equal to the user marker doubles as that marker
        phase_next = (s_tdata == tcrd_pkg::MARK_USER) ? tcrd_pkg::PH_USER0
                                                      : tcrd_pkg::PH_HUNT_UB;
      end
      tcrd_pkg::PH_HUNT_UB: begin
        if (s_tdata == tcrd_pkg::MARK_USER) begin
          phase_next = tcrd_pkg::PH_USER0;
        end else if (s_tdata == tcrd_pkg::MARK_TIME) begin
          phase_next = tcrd_pkg::PH_FRAME;   // time code restarts
        end
      end
      tcrd_pkg::PH_USER0: phase_next = tcrd_pkg::PH_USER1;
      tcrd_pkg::PH_USER1: phase_next = tcrd_pkg::PH_USER2;
      tcrd_pkg::PH_USER2: phase_next = tcrd_pkg::PH_USER3;
      tcrd_pkg::PH_USER3: phase_next = tcrd_pkg::PH_HUNT_TC;
      default: begin
        // hunting the time-code marker; a user marker skips the time
        if (s_tdata == tcrd_pkg::MARK_TIME) begin
          phase_next = tcrd_pkg::PH_FRAME;
        end else if (s_tdata == tcrd_pkg::MARK_USER) begin
          phase_next = tcrd_pkg::PH_USER0;
        end else begin
          phase_next = tcrd_pkg::PH_HUNT_TC;
        end
      end
    endcase
  end

  // held fields and flags
  always_comb begin
    held_frames_next        = held_frames;
    held_seconds_next       = held_seconds;
    held_minutes_next       = held_minutes;
    held_hours_next         = held_hours;
    partial_user_bytes_next = partial_user_bytes;
    anomaly_flags_next      = anomaly_flags;
    case (phase)
      tcrd_pkg::PH_FRAME: held_frames_next  = decoded;
      tcrd_pkg::PH_SEC:   held_seconds_next = decoded;
      tcrd_pkg::PH_MIN:   held_minutes_next = decoded;
      tcrd_pkg::PH_HOUR: begin
        held_hours_next = decoded;
        if (s_tdata == tcrd_pkg::MARK_USER) begin
          anomaly_flags_next[tcrd_pkg::FLAG_EARLY] = 1'b1;
        end
      end
      tcrd_pkg::PH_HUNT_UB: begin
        if (s_tdata != tcrd_pkg::MARK_USER) begin
          anomaly_flags_next[tcrd_pkg::FLAG_RESYNC] = 1'b1;
        end
      end
      tcrd_pkg::PH_USER0: partial_user_bytes_next = {16'd0, s_tdata};
      tcrd_pkg::PH_USER1: partial_user_bytes_next[15:8]  = s_tdata;
      tcrd_pkg::PH_USER2: partial_user_bytes_next[23:16] = s_tdata;
      tcrd_pkg::PH_USER3: begin
        partial_user_bytes_next = '0;
        anomaly_flags_next      = '0;
      end
      default: begin
        if (s_tdata != tcrd_pkg::MARK_TIME) begin
          anomaly_flags_next[tcrd_pkg::FLAG_RESYNC] = 1'b1;
          if (s_tdata == tcrd_pkg::MARK_USER) begin
            anomaly_flags_next[tcrd_pkg::FLAG_SKIPPED] = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= tcrd_pkg::PH_HUNT_TC;
      held_frames        <= '0;
      held_seconds       <= '0;
      held_minutes       <= '0;
      held_hours         <= '0;
      partial_user_bytes <= '0;
      record_counter     <= '0;
      anomaly_flags      <= '0;
    end else if (in_accept) begin
      phase              <= phase_next;
      held_frames        <= held_frames_next;
      held_seconds       <= held_seconds_next;
      held_minutes       <= held_minutes_next;
      held_hours         <= held_hours_next;
      partial_user_bytes <= partial_user_bytes_next;
      anomaly_flags      <= anomaly_flags_next;
      if (emit) begin
        record_counter <= record_counter + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {s_tdata, partial_user_bytes, held_frames, held_seconds,
                  held_minutes, held_hours, 16'(record_counter)};
      m_tuser <= anomaly_flags;
    end
  end

  // checks
  a_emit_loads_output : assert property (@(posedge clk) disable iff (rst)
    emit |=> m_tvalid && (phase == tcrd_pkg::PH_HUNT_TC))
    else $error("record not loaded or phase not back to hunting");

  a_flags_cleared : assert property (@(posedge clk) disable iff (rst)
    emit |=> (anomaly_flags == '0) && (partial_user_bytes == '0))
    else $error("flags or user bytes not cleared after a record");

  a_counter_step : assert property (@(posedge clk) disable iff (rst)
    emit |=> record_counter == $past(record_counter) + 1'b1)
    else $error("record counter did not step by one");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !emit)
    else $error("pending record overwritten");

  a_counter_hold : assert property (@(posedge clk) disable iff (rst)
    !emit |=> $stable(record_counter))
    else $error("record counter moved without a record");

endmodule

`default_nettype wire

/* test/tcrd_record_checker.sv */
// ----------------------------------------------------------------------------
// tcrd_record_checker
// watches both channels of the time-code record deframer, predicts the
// record for every byte request and compares each record request against it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcrd_record_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [79:0] m_tdata,
  input  wire logic [2:0]  m_tuser,
  input  wire logic        end_of_test,
  output int               outstanding,
  output int               error_count,
  output int               records_seen,
  output int               resync_records,
  output int               early_records,
  output int               skipped_records
);

  typedef struct packed {
    logic [15:0] number;
    logic [7:0]  hours;
    logic [7:0]  minutes;
    logic [7:0]  seconds;
    logic [7:0]  frames;
    logic [31:0] user_word;
    logic        resync;
    logic        early;
    logic        skipped;
  } record_t;

  // deframer state as predicted
  tcrd_pkg::phase_t                 deframe_phase  = tcrd_pkg::PH_HUNT_TC;
  logic [7:0]                       held_frames    = '0;
  logic [7:0]                       held_seconds   = '0;
  logic [7:0]                       held_minutes   = '0;
  logic [7:0]                       held_hours     = '0;
  logic [23:0]                      user_bytes     = '0;
  logic [tcrd_pkg::COUNT_WIDTH-1:0] record_counter = '0;
  logic [tcrd_pkg::FLAG_COUNT-1:0]  anomaly        = '0;

  record_t expected_records[$];
  int      mismatches         = 0;
  int      checked            = 0;
  int      n_resync           = 0;
  int      n_early            = 0;
  int      n_skipped          = 0;
  bit      leftovers_reported = 1'b0;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    return {4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]};
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d %s: got 0x%0h, expected 0x%0h",
                                checked, name, got, want));
  endtask

  always @(posedge clk) begin : watch
    record_t got;
    record_t want;
    if (rst) begin
      deframe_phase  = tcrd_pkg::PH_HUNT_TC;
      held_frames    = '0;
      held_seconds   = '0;
      held_minutes   = '0;
      held_hours     = '0;
      user_bytes     = '0;
      record_counter = '0;
      anomaly        = '0;
      expected_records.delete();
    end else begin
      // a record leaves in the cycle after its last byte at the earliest, so
      // it is matched before this cycle's byte adds a new expectation
      if (m_tvalid && m_tready) begin
        got.number    = m_tdata[15:0];
        got.hours     = m_tdata[23:16];
        got.minutes   = m_tdata[31:24];
        got.seconds   = m_tdata[39:32];
        got.frames    = m_tdata[47:40];
        got.user_word = m_tdata[79:48];
        got.resync    = m_tuser[tcrd_pkg::FLAG_RESYNC];
        got.early     = m_tuser[tcrd_pkg::FLAG_EARLY];
        got.skipped   = m_tuser[tcrd_pkg::FLAG_SKIPPED];
        if (expected_records.size() == 0) begin
          report_mismatch($sformatf("record 0x%0h arrived with none expected",
                                    got.number));
        end else begin
          want = expected_records.pop_front();
          check_field("record_number", 32'(got.number), 32'(want.number));
          check_field("hours", 32'(got.hours), 32'(want.hours));
          check_field("minutes", 32'(got.minutes), 32'(want.minutes));
          check_field("seconds", 32'(got.seconds), 32'(want.seconds));
          check_field("frames", 32'(got.frames), 32'(want.frames));
          check_field("user_word", got.user_word, want.user_word);
          check_field("resync_seen", 32'(got.resync), 32'(want.resync));
          check_field("early_user_marker", 32'(got.early), 32'(want.early));
          check_field("time_skipped", 32'(got.skipped), 32'(want.skipped));
        end
        checked++;
        n_resync  += int'(got.resync);
        n_early   += int'(got.early);
        n_skipped += int'(got.skipped);
      end

      if (s_tvalid && s_tready) begin
        case (deframe_phase)
          tcrd_pkg::PH_FRAME: begin
            held_frames   = bcd_to_bin(s_tdata);
            deframe_phase = tcrd_pkg::PH_SEC;
          end
          tcrd_pkg::PH_SEC: begin
            held_seconds  = bcd_to_bin(s_tdata);
            deframe_phase = tcrd_pkg::PH_MIN;
          end
          tcrd_pkg::PH_MIN: begin
            held_minutes  = bcd_to_bin(s_tdata);
            deframe_phase = tcrd_pkg::PH_HOUR;
          end
          tcrd_pkg::PH_HOUR: begin
            held_hours = bcd_to_bin(s_tdata);
            if (s_tdata == tcrd_pkg::MARK_USER) begin
              anomaly[tcrd_pkg::FLAG_EARLY] = 1'b1;
              deframe_phase                 = tcrd_pkg::PH_USER0;
            end else begin
              deframe_phase = tcrd_pkg::PH_HUNT_UB;
            end
          end
          tcrd_pkg::PH_HUNT_UB: begin
            if (s_tdata == tcrd_pkg::MARK_USER) begin
              deframe_phase = tcrd_pkg::PH_USER0;
            end else begin
              anomaly[tcrd_pkg::FLAG_RESYNC] = 1'b1;
              if (s_tdata == tcrd_pkg::MARK_TIME) deframe_phase = tcrd_pkg::PH_FRAME;
            end
          end
          tcrd_pkg::PH_USER0: begin
            user_bytes    = {16'd0, s_tdata};
            deframe_phase = tcrd_pkg::PH_USER1;
          end
          tcrd_pkg::PH_USER1: begin
            user_bytes[15:8] = s_tdata;
            deframe_phase    = tcrd_pkg::PH_USER2;
          end
          tcrd_pkg::PH_USER2: begin
            user_bytes[23:16] = s_tdata;
            deframe_phase     = tcrd_pkg::PH_USER3;
          end
          tcrd_pkg::PH_USER3: begin
            want.number    = 16'(record_counter);
            want.hours     = held_hours;
            want.minutes   = held_minutes;
            want.seconds   = held_seconds;
            want.frames    = held_frames;
            want.user_word = {s_tdata, user_bytes};
            want.resync    = anomaly[tcrd_pkg::FLAG_RESYNC];
            want.early     = anomaly[tcrd_pkg::FLAG_EARLY];
            want.skipped   = anomaly[tcrd_pkg::FLAG_SKIPPED];
            expected_records.push_back(want);
            record_counter = record_counter + 1'b1;
            anomaly        = '0;
            user_bytes     = '0;
            deframe_phase  = tcrd_pkg::PH_HUNT_TC;
          end
          default: begin
            if (s_tdata == tcrd_pkg::MARK_TIME) begin
              deframe_phase = tcrd_pkg::PH_FRAME;
            end else begin
              anomaly[tcrd_pkg::FLAG_RESYNC] = 1'b1;
              if (s_tdata == tcrd_pkg::MARK_USER) begin
                anomaly[tcrd_pkg::FLAG_SKIPPED] = 1'b1;
                deframe_phase                   = tcrd_pkg::PH_USER0;
              end else begin
                deframe_phase = tcrd_pkg::PH_HUNT_TC;
              end
            end
          end
        endcase
      end

      if (end_of_test && !leftovers_reported) begin
        if (expected_records.size() != 0)
          report_mismatch($sformatf("%0d expected records never arrived",
                                    expected_records.size()));
        leftovers_reported = 1'b1;
      end
    end

    outstanding     <= expected_records.size();
    error_count     <= mismatches;
    records_seen    <= checked;
    resync_records  <= n_resync;
    early_records   <= n_early;
    skipped_records <= n_skipped;
  end

endmodule

/* test/tb_timecode_record_deframer.sv */
// ----------------------------------------------------------------------------
// tb_timecode_record_deframer
// byte-stream test of the time-code record deframer: a directed opener for
// the marker corner cases, then mostly well-formed random records mixed with
// noise, missing markers and cut-short records, under four idle/stall mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_timecode_record_deframer;

  localparam int RANDOM_BYTES = 700;
  // a record leaves in the cycle after its last byte; the wait adds margin
  localparam int DRAIN_CYCLES = 8;

  logic        clk      = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic [7:0]  s_tdata;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [79:0] m_tdata;
  wire  [2:0]  m_tuser;

  // percent chance per cycle that the sender idles / the receiver stalls
  int idle_pct   = 0;
  int stall_pct  = 0;
  int bytes_sent = 0;

  // idle mixes of the random part: none, sender slow, receiver slow, both
  int idle_plan[4]  = '{0, 80, 0, 15};
  int stall_plan[4] = '{0, 0, 80, 15};

  logic end_of_test = 1'b0;
  int   outstanding;
  int   error_count;
  int   records_seen;
  int   resync_records;
  int   early_records;
  int   skipped_records;

  // opener: a record whose user marker is missing and whose time code
  // restarts, with the hour byte doubling as user marker and top-value
  // bcd bytes; then a user marker with no time code before it (old time
  // reused); then one clean record
  logic [7:0] directed_bytes[30] = '{
    tcrd_pkg::MARK_TIME, 8'h99, 8'h59, 8'h59, 8'h23,
    8'h13,                                  // junk while waiting for user marker
    tcrd_pkg::MARK_TIME,                    // time code starts over
    8'hFF, 8'h00, 8'h00, tcrd_pkg::MARK_USER, // hour byte is the user marker
    8'hFF, 8'hFF, 8'hFF, 8'hFF,
    tcrd_pkg::MARK_USER,                    // no time code this record
    8'h00, 8'h00, 8'h00, 8'h00,
    tcrd_pkg::MARK_TIME, 8'h12, 8'h34, 8'h56, 8'h09, tcrd_pkg::MARK_USER,
    8'hA5, 8'h5A, 8'h0F, 8'hF0
  };

  always #5 clk = ~clk;

  timecode_record_deframer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  tcrd_record_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .end_of_test     (end_of_test),
    .outstanding     (outstanding),
    .error_count     (error_count),
    .records_seen    (records_seen),
    .resync_records  (resync_records),
    .early_records   (early_records),
    .skipped_records (skipped_records)
  );

  // receiver: ready drawn fresh every cycle against the current stall rate
  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

  // one byte request: random idle cycles first, then hold valid until taken;
  // valid is left high so back-to-back requests need no second assignment
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // any byte except the two markers
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == tcrd_pkg::MARK_TIME || b == tcrd_pkg::MARK_USER);
    return b;
  endfunction

  // mostly valid decimal digits, sometimes any byte (markers included)
  function automatic logic [7:0] bcd_byte();
    if ($urandom_range(0, 99) < 75)
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    return 8'($urandom_range(0, 255));
  endfunction

  // one record, well-formed about six times in ten; the rest carry leading
  // noise, a missing time code, an early user marker, junk before the user
  // marker, a restarted time code, or stop short inside the time code
  task automatic send_record();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) repeat ($urandom_range(1, 4)) send_byte(noise_byte());
    if (kind >= 10 && kind < 16) begin
      send_byte(tcrd_pkg::MARK_USER);
    end else begin
      send_byte(tcrd_pkg::MARK_TIME);
      if (kind >= 35 && kind < 40) begin
        // next record's marker lands inside this time code
        repeat ($urandom_range(1, 4)) send_byte(bcd_byte());
        return;
      end
      repeat (3) send_byte(bcd_byte());
      if (kind >= 16 && kind < 22) begin
        send_byte(tcrd_pkg::MARK_USER);
      end else begin
        send_byte(bcd_byte());
        if (kind >= 30 && kind < 35) begin
          if ($urandom_range(0, 1)) send_byte(noise_byte());
          send_byte(tcrd_pkg::MARK_TIME);
          repeat (4) send_byte(bcd_byte());
        end
        if (kind >= 22 && kind < 30) repeat ($urandom_range(1, 4)) send_byte(noise_byte());
        send_byte(tcrd_pkg::MARK_USER);
      end
    end
    repeat (4) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int target;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      target    = bytes_sent + RANDOM_BYTES / 4;
      while (bytes_sent < target) send_record();
    end
    s_tvalid <= 1'b0;
    stall_pct = 0;

    // the checker's count is registered, so look only after the next edge
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);

    $display("run covered %0d stream bytes (%0d in the opener), %0d records checked",
             bytes_sent, $size(directed_bytes), records_seen);
    $display("records flagged: resync %0d, hour as user marker %0d, time skipped %0d",
             resync_records, early_records, skipped_records);
    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("timeout: byte or record requests stopped moving");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
